FILE: rtl/core/bcmm_pkg.sv
// ----------------------------------------------------------------------------
// bcmm_pkg
// Shared types and constants of the banked cartridge memory mapper.
// ----------------------------------------------------------------------------
package bcmm_pkg;

   localparam int RAM_DEPTH = 32768;
   localparam int RAM_AW    = 15;
   localparam int NV_WIN_AW = 12;
   localparam int ROM_AW    = 21;

   localparam logic [7:0]        DEFAULT_BANK  = 8'h7F;
   localparam logic [ROM_AW-1:0] ROM_HIGH_BASE = 21'h100000;

   // decoded address windows
   localparam logic [15:0] NV_LO_START  = 16'h0400;
   localparam logic [15:0] NV_LO_END    = 16'h1000;
   localparam logic [15:0] ROML_START   = 16'h2000;
   localparam logic [15:0] ROML_END     = 16'h8000;
   localparam logic [15:0] NV_HI_START  = 16'h9800;
   localparam logic [15:0] IO_START     = 16'h9C00;
   localparam logic [15:0] ROMH_START   = 16'hA000;
   localparam logic [15:0] ROMH_END     = 16'hC000;

   // io page register select, address bits 8:7
   localparam logic [1:0] SEL_NONE = 2'b00;
   localparam logic [1:0] SEL_HIGH = 2'b01;
   localparam logic [1:0] SEL_LOW  = 2'b10;
   localparam logic [1:0] SEL_BOTH = 2'b11;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_RESET = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_OPEN  = 2'd1,
      SRC_RAM   = 2'd2,
      SRC_NVRAM = 2'd3
   } data_src_type;

   typedef struct packed {
      logic [7:0] lo_bank;
      logic [7:0] hi_bank;
      logic       nv_enabled;
      logic       banking;
   } state_type;

   typedef struct packed {
      data_src_type          src;
      logic                  rom_read;
      logic [ROM_AW-1:0]     rom_address;
      logic                  reset_request;
      logic                  ram_re;
      logic                  ram_we;
      logic [RAM_AW-1:0]     ram_addr;
      logic                  nv_re;
      logic                  nv_we;
      logic [NV_WIN_AW-1:0]  nv_addr;
      logic                  hi_bank_we;
      logic                  lo_bank_we;
      logic                  nv_en_we;
      logic                  set_pending;
      logic                  reset_event;
   } access_type;

endpackage

FILE: rtl/core/bcmm_decode.sv
// ----------------------------------------------------------------------------
// bcmm_decode
// Address and request decode: memory strobes, rom address and register
// updates for one bus request against the current mapper state.
// ----------------------------------------------------------------------------
module bcmm_decode
   import bcmm_pkg::*;
(
   input  logic [1:0]  req_type,
   input  logic [15:0] address,
   input  state_type   state,
   output access_type  acc
);

   logic [7:0]        bl;
   logic [7:0]        bh;
   logic              ram_lo;
   logic              ram_hi;
   logic              ram_wen;
   logic              nv_area;
   logic              lo_area;
   logic              hi_area;
   logic              io_area;
   logic [RAM_AW-1:0] win_addr;
   logic [ROM_AW-1:0] rom_low;
   logic [ROM_AW-1:0] rom_high;

   always_comb begin
      bl       = state.banking ? state.lo_bank : DEFAULT_BANK;
      bh       = state.banking ? state.hi_bank : DEFAULT_BANK;
      ram_lo   = bl[7];
      ram_hi   = bh[7];
      ram_wen  = bh[6];
      nv_area  = (address >= NV_LO_START && address < NV_LO_END) ||
                 (address >= NV_HI_START && address < ROMH_START);
      lo_area  = address >= ROML_START && address < ROML_END;
      hi_area  = address >= ROMH_START && address < ROMH_END;
      io_area  = address >= IO_START && address < ROMH_START;
      // upper window folds onto the first 8 KB of ram
      win_addr = hi_area ? {2'b00, address[12:0]} : address[RAM_AW-1:0];
      rom_low  = {bl, address[12:0]};
      rom_high = {bh, address[12:0]} + ROM_HIGH_BASE;
   end

   always_comb begin
      acc          = '0;
      acc.src      = SRC_ZERO;
      acc.ram_addr = win_addr;
      acc.nv_addr  = address[NV_WIN_AW-1:0];
      case (req_type)
         REQ_READ: begin
            if (nv_area) begin
               if (state.nv_enabled) begin
                  acc.nv_re = 1'b1;
                  acc.src   = SRC_NVRAM;
               end else begin
                  acc.src = SRC_OPEN;
               end
            end else if (lo_area) begin
               if (!ram_lo) begin
                  acc.rom_read    = 1'b1;
                  acc.rom_address = rom_low;
               end else if (ram_hi) begin
                  acc.ram_re = 1'b1;
                  acc.src    = SRC_RAM;
               end else begin
                  acc.src = SRC_OPEN;
               end
            end else if (hi_area) begin
               if (!ram_hi) begin
                  acc.rom_read    = 1'b1;
                  acc.rom_address = rom_high;
               end else if (!ram_lo) begin
                  acc.rom_read    = 1'b1;
                  acc.rom_address = rom_low;
               end else begin
                  acc.ram_re = 1'b1;
                  acc.src    = SRC_RAM;
               end
            end
         end
         REQ_WRITE: begin
            acc.nv_we  = nv_area && state.nv_enabled;
            acc.ram_we = ram_wen && ram_lo && ram_hi && (lo_area || hi_area);
            if (io_area) begin
               case (address[8:7])
                  SEL_HIGH: acc.hi_bank_we = 1'b1;
                  SEL_LOW:  acc.lo_bank_we = 1'b1;
                  SEL_BOTH: begin
                     acc.hi_bank_we = 1'b1;
                     acc.lo_bank_we = 1'b1;
                     acc.nv_en_we   = 1'b1;
                  end
                  default: ;
               endcase
               acc.set_pending   = address[9];
               acc.reset_request = address[9];
            end
         end
         REQ_RESET: begin
            acc.reset_event = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/core/banked_cartridge_memory_mapper.sv
// ----------------------------------------------------------------------------
// banked_cartridge_memory_mapper
// Cartridge bus mapper with banked rom addressing, 32 KB ram and nvram.
// ----------------------------------------------------------------------------
// a request passes the read stage (ram/nvram read port), then the output
// register, before rsp_valid rises
// throughput: one request per cycle; req_ready drops only while both stages
// hold and rsp_ready is low, or while the clearing pass runs
// reset: registers clear at once, then a clearing pass zeroes every entry of
// ram and nvram, one entry per cycle, with req_ready low
module banked_cartridge_memory_mapper
   import bcmm_pkg::*;
#(
   parameter int NVRAM_DEPTH = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [15:0]         req_address,
   input  logic [7:0]          req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_read_data,
   output logic                rsp_rom_read,
   output logic [ROM_AW-1:0]   rsp_rom_address,
   output logic                rsp_reset_request
);

   localparam int NV_AW = $clog2(NVRAM_DEPTH);

   state_type         state;
   access_type        acc;
   logic              accept;
   logic              s1_adv;

   // mapper registers
   logic [7:0]        lo_bank_ff,   lo_bank_in;
   logic [7:0]        hi_bank_ff,   hi_bank_in;
   logic              nv_en_ff,     nv_en_in;
   logic              banking_ff,   banking_in;
   logic              pending_ff,   pending_in;

   // clearing pass
   logic              clear_ff,     clear_in;
   logic [RAM_AW-1:0] clear_cnt_ff, clear_cnt_in;

   // memories
   logic [7:0]        ram_mem [RAM_DEPTH];
   logic [7:0]        nv_mem  [NVRAM_DEPTH];
   logic [7:0]        ram_q_ff;
   logic [7:0]        nv_q_ff;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_wa;
   logic [7:0]        ram_wd;
   logic              nv_we;
   logic [NV_AW-1:0]  nv_wa;
   logic [7:0]        nv_wd;
   logic [NV_AW-1:0]  nv_ra;

   // read stage
   logic              s1_valid_ff, s1_valid_in;
   data_src_type      s1_src_ff;
   logic [7:0]        s1_open_ff;
   logic              s1_rom_read_ff;
   logic [ROM_AW-1:0] s1_rom_addr_ff;
   logic              s1_rst_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff,  rsp_data_in;
   logic              rsp_rom_read_ff;
   logic [ROM_AW-1:0] rsp_rom_addr_ff;
   logic              rsp_rst_ff;

   assign state = '{lo_bank:    lo_bank_ff,
                    hi_bank:    hi_bank_ff,
                    nv_enabled: nv_en_ff,
                    banking:    banking_ff};

   bcmm_decode u_decode (
      .req_type (req_type),
      .address  (req_address),
      .state    (state),
      .acc      (acc)
   );

   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !clear_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   // register updates
   always_comb begin
      lo_bank_in = lo_bank_ff;
      hi_bank_in = hi_bank_ff;
      nv_en_in   = nv_en_ff;
      banking_in = banking_ff;
      pending_in = pending_ff;
      if (accept) begin
         if (acc.lo_bank_we) begin
            lo_bank_in = req_write_data;
         end
         if (acc.hi_bank_we) begin
            hi_bank_in = req_write_data;
         end
         if (acc.nv_en_we) begin
            nv_en_in = !req_write_data[0];
         end
         if (acc.set_pending) begin
            pending_in = 1'b1;
         end
         if (acc.reset_event) begin
            banking_in = pending_ff ? !banking_ff : 1'b0;
            pending_in = 1'b0;
         end
      end
   end

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_bank_ff   <= '0;
         hi_bank_ff   <= '0;
         nv_en_ff     <= 1'b0;
         banking_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         lo_bank_ff   <= lo_bank_in;
         hi_bank_ff   <= hi_bank_in;
         nv_en_ff     <= nv_en_in;
         banking_ff   <= banking_in;
         pending_ff   <= pending_in;
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // memory ports: clearing pass owns the write port until it ends
   always_comb begin
      ram_we = clear_ff || (accept && acc.ram_we);
      ram_wa = clear_ff ? clear_cnt_ff : acc.ram_addr;
      ram_wd = clear_ff ? 8'h00 : req_write_data;
      nv_we  = clear_ff ? (clear_cnt_ff < RAM_AW'(NVRAM_DEPTH)) : (accept && acc.nv_we);
      nv_wa  = clear_ff ? clear_cnt_ff[NV_AW-1:0] : NV_AW'(acc.nv_addr);
      nv_wd  = clear_ff ? 8'h00 : req_write_data;
      nv_ra  = NV_AW'(acc.nv_addr);
   end

   // read data holds while the read stage is stalled: no new read is issued
   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_wa] <= ram_wd;
      end
      if (reset) begin
         ram_q_ff <= '0;
      end else if (accept && acc.ram_re) begin
         ram_q_ff <= ram_mem[acc.ram_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (nv_we) begin
         nv_mem[nv_wa] <= nv_wd;
      end
      if (reset) begin
         nv_q_ff <= '0;
      end else if (accept && acc.nv_re) begin
         nv_q_ff <= nv_mem[nv_ra];
      end
   end

   // read stage and output register
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
      case (s1_src_ff)
         SRC_OPEN:  rsp_data_in = s1_open_ff;
         SRC_RAM:   rsp_data_in = ram_q_ff;
         SRC_NVRAM: rsp_data_in = nv_q_ff;
         default:   rsp_data_in = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff      <= acc.src;
         s1_open_ff     <= req_address[15:8];
         s1_rom_read_ff <= acc.rom_read;
         s1_rom_addr_ff <= acc.rom_address;
         s1_rst_ff      <= acc.reset_request;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff     <= rsp_data_in;
         rsp_rom_read_ff <= s1_rom_read_ff;
         rsp_rom_addr_ff <= s1_rom_addr_ff;
         rsp_rst_ff      <= s1_rst_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_rom_read      = rsp_rom_read_ff;
   assign rsp_rom_address   = rsp_rom_addr_ff;
   assign rsp_reset_request = rsp_rst_ff;

   a_rom_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rom_read |-> rsp_read_data == 8'h00)
      else $error("rom read response carries data");

   a_rst_no_rom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reset_request |-> !rsp_rom_read)
      else $error("reset request on a rom read");

   a_accept_to_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request lost before read stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(ram_q_ff) && $stable(nv_q_ff))
      else $error("read stage changed while stalled");

   a_clear_length: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> $past(clear_cnt_ff) == RAM_AW'(RAM_DEPTH - 1))
      else $error("clearing pass ended early");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus reads, bus writes and machine reset events into the cartridge
// mapper and checks every response against a behavioral model of the banks,
// the ram and the nvram kept inside this module.
// ----------------------------------------------------------------------------
module testbench
   import bcmm_pkg::*;
();

   localparam realtime CLOCK_PERIOD   = 12.0;
   localparam int      NV_DEPTH       = 4096;
   localparam int      TIMEOUT_CYCLES = 400_000;
   localparam int      IDLE_PERCENT   = 31;

   // request code the block has no use for
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0]        read_data;
      logic              rom_read;
      logic [ROM_AW-1:0] rom_address;
      logic              reset_request;
   } mapper_result_type;

   logic              clock;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_ready;
   logic [1:0]        req_type          = REQ_READ;
   logic [15:0]       req_address       = '0;
   logic [7:0]        req_write_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready         = 1'b0;
   logic [7:0]        rsp_read_data;
   logic              rsp_rom_read;
   logic [ROM_AW-1:0] rsp_rom_address;
   logic              rsp_reset_request;

   // model of the mapper state
   logic [7:0] model_lo_bank      = '0;
   logic [7:0] model_hi_bank      = '0;
   logic       model_nv_on        = 1'b0;
   logic       model_banking      = 1'b0;
   logic       model_reset_armed  = 1'b0;
   logic [7:0] ram_image   [RAM_DEPTH] = '{default: 8'h00};
   logic [7:0] nvram_image [NV_DEPTH]  = '{default: 8'h00};

   mapper_result_type expected_results [$];
   mapper_result_type oldest_result;
   int                mismatch_count = 0;
   logic              steady_traffic = 1'b0;

   banked_cartridge_memory_mapper #(
      .NVRAM_DEPTH(NV_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_rom_read     (rsp_rom_read),
      .rsp_rom_address  (rsp_rom_address),
      .rsp_reset_request(rsp_reset_request)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // model
   // --------------------------------------------------------------------------
   function automatic logic [ROM_AW-1:0] rom_location(logic [15:0] addr, logic [7:0] bank,
                                                      logic high_rom);
      logic [ROM_AW-1:0] loc;
      loc = {bank, addr[12:0]};
      if (high_rom) begin
         loc = loc + ROM_HIGH_BASE;
      end
      return loc;
   endfunction

   function automatic mapper_result_type map_bus_access(logic [1:0] kind, logic [15:0] addr,
                                                        logic [7:0] wdata);
      mapper_result_type res;
      logic [7:0]        bl;
      logic [7:0]        bh;
      logic              lo_ram;
      logic              hi_ram;
      logic              ram_wr;
      logic              nv_win;
      logic              roml_win;
      logic              romh_win;
      logic [7:0]        open_bus;
      int                nv_idx;
      res      = '0;
      bl       = model_banking ? model_lo_bank : DEFAULT_BANK;
      bh       = model_banking ? model_hi_bank : DEFAULT_BANK;
      lo_ram   = bl[7];
      hi_ram   = bh[7];
      ram_wr   = bh[6];
      nv_win   = (addr >= NV_LO_START && addr < NV_LO_END) ||
                 (addr >= NV_HI_START && addr < ROMH_START);
      roml_win = addr >= ROML_START && addr < ROML_END;
      romh_win = addr >= ROMH_START && addr < ROMH_END;
      open_bus = addr[15:8];
      nv_idx   = int'(addr[11:0]) % NV_DEPTH;
      case (kind)
         REQ_READ: begin
            if (nv_win) begin
               res.read_data = model_nv_on ? nvram_image[nv_idx] : open_bus;
            end else if (roml_win) begin
               if (!lo_ram) begin
                  res.rom_read    = 1'b1;
                  res.rom_address = rom_location(addr, bl, 1'b0);
               end else begin
                  res.read_data = hi_ram ? ram_image[addr[14:0]] : open_bus;
               end
            end else if (romh_win) begin
               if (!hi_ram) begin
                  res.rom_read    = 1'b1;
                  res.rom_address = rom_location(addr, bh, 1'b1);
               end else if (!lo_ram) begin
                  res.rom_read    = 1'b1;
                  res.rom_address = rom_location(addr, bl, 1'b0);
               end else begin
                  res.read_data = ram_image[{2'b00, addr[12:0]}];
               end
            end
         end
         REQ_WRITE: begin
            if (nv_win && model_nv_on) begin
               nvram_image[nv_idx] = wdata;
            end
            if (ram_wr && lo_ram && hi_ram) begin
               if (roml_win) begin
                  ram_image[addr[14:0]] = wdata;
               end else if (romh_win) begin
                  ram_image[{2'b00, addr[12:0]}] = wdata;
               end
            end
            if (addr >= IO_START && addr < ROMH_START) begin
               case (addr[8:7])
                  SEL_HIGH: model_hi_bank = wdata;
                  SEL_LOW:  model_lo_bank = wdata;
                  SEL_BOTH: begin
                     model_nv_on   = !wdata[0];
                     model_hi_bank = wdata;
                     model_lo_bank = wdata;
                  end
                  default: ;
               endcase
               // soft reset bit acts on top of the bank select
               if (addr[9]) begin
                  model_reset_armed = 1'b1;
                  res.reset_request = 1'b1;
               end
            end
         end
         REQ_RESET: begin
            model_banking     = model_reset_armed ? !model_banking : 1'b0;
            model_reset_armed = 1'b0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // --------------------------------------------------------------------------
   // request side
   // --------------------------------------------------------------------------
   task automatic issue_request(logic [1:0] kind, logic [15:0] addr, logic [7:0] wdata);
      while (!steady_traffic && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_address    <= addr;
      req_write_data <= wdata;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // valid stays high here so back-to-back requests need no second assignment
      expected_results.push_back(map_bus_access(kind, addr, wdata));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // response side
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= steady_traffic || ($urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", 32'd1, 32'd0);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_read_data !== oldest_result.read_data) begin
               report_mismatch("read_data", 32'(rsp_read_data),
                               32'(oldest_result.read_data));
            end
            if (rsp_rom_read !== oldest_result.rom_read) begin
               report_mismatch("rom_read", 32'(rsp_rom_read),
                               32'(oldest_result.rom_read));
            end
            if (rsp_rom_address !== oldest_result.rom_address) begin
               report_mismatch("rom_address", 32'(rsp_rom_address),
                               32'(oldest_result.rom_address));
            end
            if (rsp_reset_request !== oldest_result.reset_request) begin
               report_mismatch("reset_request", 32'(rsp_reset_request),
                               32'(oldest_result.reset_request));
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------
   // banking off: both banks read as default, nvram disabled
   task automatic test_power_on_decode();
      issue_request(REQ_READ, 16'h0000, 8'h00);
      issue_request(REQ_READ, 16'h2000, 8'h00);
      issue_request(REQ_READ, 16'hBFFF, 8'h00);
      issue_request(REQ_READ, 16'h0400, 8'h00);
      issue_request(REQ_READ, 16'hFFFF, 8'hFF);
      issue_request(REQ_UNUSED, 16'hFFFF, 8'hFF);
      issue_request(REQ_WRITE, 16'h0400, 8'hFF);
   endtask

   task automatic test_nvram_and_banks();
      issue_request(REQ_WRITE, 16'h9D80, 8'h00);   // both banks, nvram on
      issue_request(REQ_WRITE, 16'h0FFF, 8'hA5);
      issue_request(REQ_READ, 16'h9FFF, 8'h00);    // same nvram byte, upper window
      issue_request(REQ_WRITE, 16'h9E00, 8'hC0);   // soft reset request
      issue_request(REQ_RESET, 16'h0000, 8'h00);   // armed, banking turns on
      issue_request(REQ_READ, 16'h2000, 8'h00);
      issue_request(REQ_WRITE, 16'h9C80, 8'h7F);
      issue_request(REQ_READ, 16'hBFFF, 8'h00);    // top of rom space
      issue_request(REQ_WRITE, 16'h9D00, 8'hFF);
      issue_request(REQ_READ, 16'h2000, 8'h00);    // low ram on, high ram off
   endtask

   task automatic test_ram_window();
      issue_request(REQ_WRITE, 16'h9C80, 8'hC0);   // high ram plus write enable
      issue_request(REQ_WRITE, 16'h7FFF, 8'hFF);
      issue_request(REQ_WRITE, 16'hBFFF, 8'h5A);
      issue_request(REQ_READ, 16'h7FFF, 8'h00);
      issue_request(REQ_READ, 16'hA000, 8'h00);
      issue_request(REQ_RESET, 16'hFFFF, 8'hFF);   // not armed, banking cleared
      issue_request(REQ_READ, 16'hA000, 8'h00);
      issue_request(REQ_WRITE, 16'h9FFF, 8'h01);   // both banks, nvram off, soft reset
   endtask

   task automatic test_random_traffic(int count);
      logic [15:0] addr;
      logic [15:0] io_addr;
      logic [7:0]  data;
      logic [7:0]  bank_data;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick      = $urandom_range(99);
         data      = 8'($urandom);
         bank_data = 8'($urandom);
         if ($urandom_range(1) == 1) begin
            bank_data[7:6] = 2'b11;
         end
         if ($urandom_range(2) != 0) begin
            bank_data[0] = 1'b0;
         end
         io_addr = IO_START | 16'($urandom_range(1023));
         case ($urandom_range(7))
            0:       addr = 16'($urandom_range(NV_LO_END - 1, NV_LO_START));
            1, 2:    addr = 16'($urandom_range(ROML_END - 1, ROML_START));
            3, 4:    addr = 16'($urandom_range(ROMH_END - 1, ROMH_START));
            5:       addr = 16'($urandom_range(ROMH_START - 1, NV_HI_START));
            default: addr = 16'($urandom);
         endcase
         if (pick < 8) begin
            // bank setup followed by the machine reset that applies it
            io_addr[9] = 1'b1;
            issue_request(REQ_WRITE, io_addr, bank_data);
            issue_request(REQ_RESET, 16'($urandom), 8'($urandom));
         end else if (pick < 16) begin
            io_addr[9] = 1'b0;
            issue_request(REQ_WRITE, io_addr, bank_data);
         end else if (pick < 21) begin
            issue_request(REQ_RESET, addr, data);
         end else if (pick < 24) begin
            issue_request(REQ_UNUSED, addr, data);
         end else if (pick < 62) begin
            issue_request(REQ_READ, addr, data);
         end else begin
            issue_request(REQ_WRITE, addr, data);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_power_on_decode();
      test_nvram_and_banks();
      test_ram_window();
      test_random_traffic(270);
      drain_results();
      steady_traffic <= 1'b1;
      test_random_traffic(220);
      drain_results();
      steady_traffic <= 1'b0;
      test_random_traffic(270);
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("banked_cartridge_memory_mapper test passed");
      end else begin
         $display("banked_cartridge_memory_mapper test failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d responses outstanding", expected_results.size());
      $display("banked_cartridge_memory_mapper test failed");
      $finish;
   end

endmodule
